// ===== rtl/mlp_forward_sigmoid_assert.svh =====
// Assertion macros for the MLP forward pass block.
`ifndef MLP_FORWARD_SIGMOID_ASSERT_SVH
`define MLP_FORWARD_SIGMOID_ASSERT_SVH

`ifndef SYNTHESIS
`define MFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MFS_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define MFS_ASSERT(label, prop, msg)
`define MFS_ASSERT_IMP(label, pre, post, msg)
`endif

`endif

// ===== rtl/mfs_pkg.sv =====
// Shared types, codes, defaults and the sigmoid table of the MLP forward pass block.
package mfs_pkg;

  localparam int MFS_MAX_LAYERS = 4;
  localparam int MFS_MAX_NODES  = 16;

  typedef enum logic {
    MODE_WEIGHT = 1'b0,
    MODE_ACT    = 1'b1
  } mfs_mode_e;

  typedef enum logic [2:0] {
    REG_LAYER_COUNT = 3'd0,
    REG_NODES0      = 3'd1,
    REG_NODES1      = 3'd2,
    REG_NODES2      = 3'd3,
    REG_NODES3      = 3'd4
  } mfs_reg_e;

  localparam int SIG_ENTRIES = 256;

  typedef logic [SIG_ENTRIES-1:0][12:0] sig_table_t;

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825045;
  localparam logic [63:0] ONE_Q32      = 64'd4294967296;

  // Bin centers at +m/32 use e^-m/32 built by repeated Q32 multiply, then a
  // rounded long division; negative centers take 1.0 minus the mirrored entry.
  function automatic sig_table_t sig_table_build();
    logic [63:0] pw;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    sig_table_t  pos;
    sig_table_t  t;
    pw  = ONE_Q32;
    pos = '0;
    t   = '0;
    for (int m = 1; m < SIG_ENTRIES; m++) begin
      pw  = (pw * EXP_STEP_Q32 + (ONE_Q32 >> 1)) >> 32;
      den = ONE_Q32 + pw;
      num = (64'd1 << 44) + (den >> 1);
      rem = '0;
      quo = '0;
      for (int b = 46; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem    = rem - den;
          quo[b] = 1'b1;
        end
      end
      pos[m] = quo[12:0];
    end
    pos[0] = 13'd2048;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      if (i >= SIG_ENTRIES / 2) begin
        t[i] = pos[2 * i + 1 - SIG_ENTRIES];
      end else begin
        t[i] = 13'd4096 - pos[SIG_ENTRIES - 1 - 2 * i];
      end
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = sig_table_build();

endpackage

// ===== rtl/mlp_forward_sigmoid.sv =====
// MLP forward pass with sigmoid activations on one shared multiply-accumulate unit.
//
//  channel   direction  handshake               payload
//  in        sink       in_valid_i/in_stall_o    mode, target_layer, node/source index, value, last
//  out       source     out_valid_o/out_stall_i  out_index, out_value, last_output
//  cfg       sink       cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// Weight and plain activation items are taken while the block is idle and start no pass.
// An item with last_input starts a pass: each node of layer l reads all nodes of layer
// l-1 on the single MAC (one read pair per cycle from the weight and activation
// memories), then drains, rounds and writes the table lookup; results are emitted in turn.
// Reset restores the register defaults; the memories hold garbage until written.
// A stalled output holds the emission; input is stalled until the last result is loaded.
`include "mlp_forward_sigmoid_assert.svh"

module mlp_forward_sigmoid
  import mfs_pkg::*;
#(
  parameter int MAX_LAYERS = MFS_MAX_LAYERS,
  parameter int MAX_NODES  = MFS_MAX_NODES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [1:0]         target_layer_i,
  input  logic [3:0]         node_index_i,
  input  logic [3:0]         source_index_i,
  input  logic signed [15:0] value_i,
  input  logic               last_input_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         out_index_o,
  output logic signed [15:0] out_value_o,
  output logic               last_output_o
);

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int LW         = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS - 1) : 1;
  localparam int WADDR_W    = LW + 2 * NODE_W;
  localparam int WDEPTH     = (MAX_LAYERS - 1) * (2 ** (2 * NODE_W));
  localparam int AADDR_W    = 2 + NODE_W;
  localparam int ADEPTH     = 3 * (2 ** NODE_W);
  localparam int TOP_LAYERS = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
  localparam int ACC_W      = 33 + NODE_W;

  localparam logic [1:0] ROW_IN = 2'd0;
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-32768);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2048);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_WRITE,
    ST_EMIT,
    ST_EMIT_LD
  } state_e;

  function automatic logic [CNT_W-1:0] clamp_nodes(logic [4:0] v);
    if (v == 5'd0) begin
      return CNT_W'(1);
    end
    if (int'(v) > MAX_NODES) begin
      return CNT_W'(MAX_NODES);
    end
    return CNT_W'(v);
  endfunction

  // configuration registers
  logic [2:0] layer_count_q;
  logic [4:0] nodes0_q, nodes1_q, nodes2_q, nodes3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= 3'd2;
      nodes0_q      <= 5'd16;
      nodes1_q      <= 5'd16;
      nodes2_q      <= 5'd16;
      nodes3_q      <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LAYER_COUNT: layer_count_q <= cfg_wdata_i[2:0];
        REG_NODES0:      nodes0_q      <= cfg_wdata_i;
        REG_NODES1:      nodes1_q      <= cfg_wdata_i;
        REG_NODES2:      nodes2_q      <= cfg_wdata_i;
        REG_NODES3:      nodes3_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  function automatic logic [4:0] nodes_sel(logic [1:0] layer, logic [4:0] n0, logic [4:0] n1,
                                           logic [4:0] n2, logic [4:0] n3);
    case (layer)
      2'd0:    return n0;
      2'd1:    return n1;
      2'd2:    return n2;
      default: return n3;
    endcase
  endfunction

  state_e                   state_q;
  logic [1:0]               l_q;
  logic [1:0]               cur_q;
  logic [CNT_W-1:0]         j_q;
  logic [CNT_W-1:0]         k_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [15:0]       x_q;
  logic                     rd_v_q;
  logic                     prod_v_q;
  logic signed [15:0]       w_rd_q;
  logic signed [15:0]       a_rd_q;
  logic signed [31:0]       prod_q;
  logic                     out_valid_q;
  logic [3:0]               out_index_q;
  logic signed [15:0]       out_value_q;
  logic                     out_last_q;

  logic                     in_acc;
  logic [2:0]               layers_use;
  logic [CNT_W-1:0]         np;
  logic [CNT_W-1:0]         n_cur;
  logic [CNT_W-1:0]         n_out;
  logic [1:0]               dst_row;
  logic                     w_we;
  logic [WADDR_W-1:0]       w_waddr;
  logic [WADDR_W-1:0]       w_raddr;
  logic                     a_we;
  logic                     fsm_we;
  logic [AADDR_W-1:0]       a_waddr;
  logic [AADDR_W-1:0]       a_raddr;
  logic signed [15:0]       a_wdata;
  logic [7:0]               sig_idx;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shr;
  logic signed [15:0]       sat;
  logic                     out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    layers_use = layer_count_q;
    if (layer_count_q == 3'd0) begin
      layers_use = 3'd1;
    end else if (int'(layer_count_q) > TOP_LAYERS) begin
      layers_use = 3'(TOP_LAYERS);
    end
  end

  assign np    = clamp_nodes(nodes_sel(l_q - 2'd1, nodes0_q, nodes1_q, nodes2_q, nodes3_q));
  assign n_cur = clamp_nodes(nodes_sel(l_q, nodes0_q, nodes1_q, nodes2_q, nodes3_q));
  assign n_out = clamp_nodes(nodes_sel(2'(layers_use - 3'd1), nodes0_q, nodes1_q,
                                       nodes2_q, nodes3_q));

  assign dst_row = (cur_q == 2'd1) ? 2'd2 : 2'd1;

  // weight memory: one write from items, one read for the MAC
  assign w_we = in_acc && (mode_i == MODE_WEIGHT) && (target_layer_i != 2'd0)
             && (int'(target_layer_i) < MAX_LAYERS) && (int'(node_index_i) < MAX_NODES)
             && (int'(source_index_i) < MAX_NODES);
  assign w_waddr = {LW'(target_layer_i - 2'd1), NODE_W'(node_index_i),
                    NODE_W'(source_index_i)};
  assign w_raddr = {LW'(l_q - 2'd1), j_q[NODE_W-1:0], k_q[NODE_W-1:0]};

  logic signed [15:0] weight_mem [WDEPTH];

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      weight_mem[w_waddr] <= value_i;
    end
    w_rd_q <= weight_mem[w_raddr];
  end

  // activation memory: input row plus two working rows
  assign sig_idx = {~x_q[15], x_q[14:8]};
  assign fsm_we  = (state_q == ST_WRITE);
  assign a_we    = fsm_we || (in_acc && (mode_i == MODE_ACT)
                              && (int'(node_index_i) < MAX_NODES));
  assign a_waddr = fsm_we ? {dst_row, j_q[NODE_W-1:0]} : {ROW_IN, NODE_W'(node_index_i)};
  assign a_wdata = fsm_we ? $signed({3'b000, SIG_TABLE[sig_idx]}) : value_i;
  assign a_raddr = (state_q == ST_EMIT) ? {cur_q, j_q[NODE_W-1:0]}
                                        : {cur_q, k_q[NODE_W-1:0]};

  logic signed [15:0] act_mem [ADEPTH];

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      act_mem[a_waddr] <= a_wdata;
    end
    a_rd_q <= act_mem[a_raddr];
  end

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      prod_q   <= '0;
    end else begin
      rd_v_q   <= (state_q == ST_MAC);
      prod_v_q <= rd_v_q;
      prod_q   <= w_rd_q * a_rd_q;
    end
  end

  assign rnd = acc_q + RND_HALF;
  assign shr = rnd >>> 12;

  always_comb begin
    if (shr > SAT_HI) begin
      sat = 16'sh7FFF;
    end else if (shr < SAT_LO) begin
      sat = -16'sh8000;
    end else begin
      sat = shr[15:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      l_q         <= 2'd1;
      cur_q       <= ROW_IN;
      j_q         <= '0;
      k_q         <= '0;
      acc_q       <= '0;
      x_q         <= '0;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (prod_v_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (mode_i == MODE_ACT) && last_input_i) begin
            l_q   <= 2'd1;
            cur_q <= ROW_IN;
            j_q   <= '0;
            k_q   <= '0;
            acc_q <= '0;
            state_q <= (layers_use == 3'd1) ? ST_EMIT : ST_MAC;
          end
        end
        ST_MAC: begin
          if (k_q == np - CNT_W'(1)) begin
            k_q     <= '0;
            state_q <= ST_DRAIN;
          end else begin
            k_q <= k_q + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!rd_v_q && !prod_v_q) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          x_q     <= sat;
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          acc_q <= '0;
          if (j_q == n_cur - CNT_W'(1)) begin
            j_q   <= '0;
            cur_q <= dst_row;
            if ({1'b0, l_q} == layers_use - 3'd1) begin
              state_q <= ST_EMIT;
            end else begin
              l_q     <= l_q + 2'd1;
              state_q <= ST_MAC;
            end
          end else begin
            j_q     <= j_q + CNT_W'(1);
            state_q <= ST_MAC;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_EMIT_LD;
          end
        end
        ST_EMIT_LD: begin
          out_valid_q <= 1'b1;
          out_index_q <= 4'(j_q);
          out_value_q <= a_rd_q;
          out_last_q  <= (j_q == n_out - CNT_W'(1));
          if (j_q == n_out - CNT_W'(1)) begin
            j_q     <= '0;
            state_q <= ST_IDLE;
          end else begin
            j_q     <= j_q + CNT_W'(1);
            state_q <= ST_EMIT;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign out_value_o   = out_value_q;
  assign last_output_o = out_last_q;

  `MFS_ASSERT_IMP(a_load_free, state_q == ST_EMIT_LD, !out_valid_q, "output overwritten")
  `MFS_ASSERT_IMP(a_prod_in_pass, prod_v_q, state_q == ST_MAC || state_q == ST_DRAIN,
                  "product outside of a dot product")
  `MFS_ASSERT_IMP(a_round_drained, state_q == ST_ROUND, !rd_v_q && !prod_v_q,
                  "rounding before the pipeline drained")
  `MFS_ASSERT_IMP(a_src_in_range, state_q == ST_MAC, k_q < np, "source index past layer size")

endmodule

// ===== test/mlp_forward_sigmoid_chk.sv =====
// Checker for mlp_forward_sigmoid: models each forward pass from observed items and compares results.
module mlp_forward_sigmoid_chk
  import mfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               mode_i,
  input  logic [1:0]         target_layer_i,
  input  logic [3:0]         node_index_i,
  input  logic [3:0]         source_index_i,
  input  logic signed [15:0] value_i,
  input  logic               last_input_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [3:0]         out_index_o,
  input  logic signed [15:0] out_value_o,
  input  logic               last_output_o,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        passes_o,
  output int unsigned        results_o
);

  localparam longint unsigned EXP_STEP = 64'd4162825045;
  localparam longint unsigned ONE_Q32  = 64'd1 << 32;

  typedef logic signed [15:0] q412_t;

  typedef struct packed {
    logic [3:0] index;
    q412_t      value;
    logic       last;
  } node_result_t;

  logic [2:0]   layer_count_q;
  logic [4:0]   node_count_q [MFS_MAX_LAYERS];
  q412_t        weights [MFS_MAX_LAYERS-1][MFS_MAX_NODES][MFS_MAX_NODES];
  q412_t        inputs_q [MFS_MAX_NODES];
  logic [12:0]  sigmoid_lut [SIG_ENTRIES];
  node_result_t expected_outputs [$];

  initial begin : build_lut
    longint unsigned pw;
    longint unsigned den;
    logic [12:0]     pos [SIG_ENTRIES];
    pw     = ONE_Q32;
    pos[0] = 13'd2048;
    for (int m = 1; m < SIG_ENTRIES; m++) begin
      pw     = (pw * EXP_STEP + (ONE_Q32 >> 1)) >> 32;
      den    = ONE_Q32 + pw;
      pos[m] = 13'(((64'd1 << 44) + (den >> 1)) / den);
    end
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      if (i >= SIG_ENTRIES / 2) begin
        sigmoid_lut[i] = pos[2 * i + 1 - SIG_ENTRIES];
      end else begin
        sigmoid_lut[i] = 13'd4096 - pos[SIG_ENTRIES - 1 - 2 * i];
      end
    end
  end

  function automatic int unsigned layers_used();
    int unsigned v;
    v = layer_count_q;
    if (v < 1) v = 1;
    if (v > MFS_MAX_LAYERS) v = MFS_MAX_LAYERS;
    return v;
  endfunction

  function automatic int unsigned nodes_in(int unsigned layer);
    int unsigned v;
    v = node_count_q[layer];
    if (v < 1) v = 1;
    if (v > MFS_MAX_NODES) v = MFS_MAX_NODES;
    return v;
  endfunction

  function automatic q412_t activate(longint acc);
    longint q;
    q = (acc + 2048) >>> 12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return {3'b000, sigmoid_lut[int'((q + 32768) >>> 8)]};
  endfunction

  function automatic void forward_pass();
    q412_t        row [MFS_MAX_NODES];
    q412_t        next_row [MFS_MAX_NODES];
    longint       acc;
    int unsigned  n_layers;
    int unsigned  n;
    node_result_t r;
    row      = inputs_q;
    next_row = inputs_q;
    n_layers = layers_used();
    for (int l = 1; l < n_layers; l++) begin
      for (int j = 0; j < nodes_in(l); j++) begin
        acc = 0;
        for (int k = 0; k < nodes_in(l - 1); k++) begin
          acc += longint'(weights[l-1][j][k]) * longint'(row[k]);
        end
        next_row[j] = activate(acc);
      end
      row = next_row;
    end
    n = nodes_in(n_layers - 1);
    for (int j = 0; j < n; j++) begin
      r.index = 4'(j);
      r.value = row[j];
      r.last  = (j == n - 1);
      expected_outputs.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    node_result_t want;
    if (!rst_ni) begin
      layer_count_q = 3'd2;
      for (int l = 0; l < MFS_MAX_LAYERS; l++) node_count_q[l] = 5'd16;
      expected_outputs.delete();
      fail_count_o = 0;
      passes_o     = 0;
      results_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_LAYER_COUNT) begin
          layer_count_q = cfg_wdata_i[2:0];
        end else if (cfg_index_i <= REG_NODES3) begin
          node_count_q[cfg_index_i - REG_NODES0] = cfg_wdata_i;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        results_o++;
        if (expected_outputs.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected result index %0d value %0d last %0b", $time,
                     out_index_o, out_value_o, last_output_o);
          fail_count_o++;
        end else begin
          want = expected_outputs.pop_front();
          if (want.index !== out_index_o || want.value !== out_value_o ||
              want.last !== last_output_o) begin
            if (fail_count_o < 10)
              $display("%0t: got index %0d value %0d last %0b, expected %0d %0d %0b",
                       $time, out_index_o, out_value_o, last_output_o,
                       want.index, want.value, want.last);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (mode_i == MODE_WEIGHT) begin
          if (target_layer_i != 2'd0)
            weights[target_layer_i - 1][node_index_i][source_index_i] = value_i;
        end else begin
          inputs_q[node_index_i] = value_i;
          if (last_input_i) begin
            forward_pass();
            passes_o++;
          end
        end
      end
    end
    pending_o = expected_outputs.size();
  end

endmodule

// ===== test/mlp_forward_sigmoid_tb.sv =====
// Testbench top for mlp_forward_sigmoid: clock, reset, register setup, item stimulus and verdict.
module mlp_forward_sigmoid_tb
  import mfs_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS  = 220;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned SETTLE_CYCLES = 32;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [2:0]         cfg_index_i    = '0;
  logic [4:0]         cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               mode_i         = 1'b0;
  logic [1:0]         target_layer_i = '0;
  logic [3:0]         node_index_i   = '0;
  logic [3:0]         source_index_i = '0;
  logic signed [15:0] value_i        = '0;
  logic               last_input_i   = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [3:0]         out_index_o;
  logic signed [15:0] out_value_o;
  logic               last_output_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned passes_run;
  int unsigned results_seen;

  int unsigned shape_layers;
  int unsigned shape_nodes [MFS_MAX_LAYERS];
  bit          weight_set [MFS_MAX_LAYERS-1][MFS_MAX_NODES][MFS_MAX_NODES];
  bit          input_set [MFS_MAX_NODES];
  bit          no_gaps      = 1'b0;
  int unsigned items_sent   = 0;
  int unsigned configs_used = 0;
  int unsigned idle_cycles  = 0;
  int unsigned stall_left   = 0;

  mlp_forward_sigmoid dut (.*);

  mlp_forward_sigmoid_chk chk (
    .*,
    .fail_count_o (mismatches),
    .pending_o    (pending),
    .passes_o     (passes_run),
    .results_o    (results_seen)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      stall_left = no_gaps ? 0 : $urandom_range(0, 10);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [15:0] rand_q();
    int v;
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: begin
        v = $urandom_range(0, 8192);
        return 16'(v - 4096);
      end
    endcase
  endfunction

  function automatic logic [4:0] layer_code(int unsigned n);
    if (n == MFS_MAX_LAYERS && $urandom_range(0, 1)) return {2'($urandom), 3'($urandom_range(4, 7))};
    if (n == 1 && $urandom_range(0, 1)) return {2'($urandom), 3'd0};
    return {2'($urandom), 3'(n)};
  endfunction

  function automatic logic [4:0] count_code(int unsigned n);
    if (n == MFS_MAX_NODES && $urandom_range(0, 1)) return 5'($urandom_range(16, 31));
    if (n == 1 && $urandom_range(0, 1)) return 5'd0;
    return 5'(n);
  endfunction

  task automatic send(mfs_mode_e mode, logic [1:0] layer, logic [3:0] node, logic [3:0] src,
                      logic signed [15:0] val, logic last);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    target_layer_i <= layer;
    node_index_i   <= node;
    source_index_i <= src;
    value_i        <= val;
    last_input_i   <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic put_weight(logic [1:0] layer, logic [3:0] node, logic [3:0] src,
                            logic signed [15:0] val, logic last);
    send(MODE_WEIGHT, layer, node, src, val, last);
    if (layer != 2'd0) weight_set[layer - 1][node][src] = 1'b1;
  endtask

  task automatic put_input(logic [3:0] node, logic signed [15:0] val, logic last);
    send(MODE_ACT, 2'($urandom), node, 4'($urandom), val, last);
    input_set[node] = 1'b1;
  endtask

  task automatic program_shape();
    cfg_we_i <= 1'b1;
    for (int r = REG_LAYER_COUNT; r <= REG_NODES3; r++) begin
      cfg_index_i <= 3'(r);
      cfg_wdata_i <= (r == REG_LAYER_COUNT) ? layer_code(shape_layers)
                                            : count_code(shape_nodes[r - REG_NODES0]);
      @(posedge clk_i);
    end
    if ($urandom_range(0, 3) == 0) begin
      cfg_index_i <= 3'($urandom_range(REG_NODES3 + 1, 7));
      cfg_wdata_i <= 5'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    configs_used++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic fill_missing();
    for (int k = 0; k < shape_nodes[0]; k++) begin
      if (!input_set[k]) put_input(4'(k), rand_q(), 1'b0);
    end
    for (int l = 1; l < shape_layers; l++) begin
      for (int j = 0; j < shape_nodes[l]; j++) begin
        for (int k = 0; k < shape_nodes[l-1]; k++) begin
          if (!weight_set[l-1][j][k]) put_weight(2'(l), 4'(j), 4'(k), rand_q(), 1'b0);
        end
      end
    end
  endtask

  task automatic random_pass();
    int unsigned l;
    fill_missing();
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        0: put_weight(2'd0, 4'($urandom), 4'($urandom), rand_q(), 1'($urandom));
        1: put_weight(2'($urandom_range(1, 3)), 4'($urandom), 4'($urandom), rand_q(), 1'b1);
        2: put_input(4'($urandom), rand_q(), 1'b0);
        3, 4, 5: begin
          if (shape_layers > 1) begin
            l = $urandom_range(1, shape_layers - 1);
            put_weight(2'(l), 4'($urandom_range(0, shape_nodes[l] - 1)),
                       4'($urandom_range(0, shape_nodes[l-1] - 1)), rand_q(), 1'b0);
          end else begin
            put_input(4'($urandom_range(0, shape_nodes[0] - 1)), rand_q(), 1'b0);
          end
        end
        default: put_input(4'($urandom_range(0, shape_nodes[0] - 1)), rand_q(), 1'b0);
      endcase
    end
    put_input(4'($urandom), rand_q(), 1'b1);
  endtask

  initial begin
    int unsigned random_start;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single layer: stored inputs come straight back
    shape_layers = 1;
    shape_nodes  = '{3, 1, 1, 1};
    program_shape();
    put_input(0, 16'h7FFF, 1'b0);
    put_input(1, 16'h8000, 1'b0);
    put_input(2, 16'h0000, 1'b1);
    settle();

    // saturate the dot product both ways, plus dropped and ignored items
    shape_layers = 2;
    shape_nodes  = '{2, 2, 16, 16};
    program_shape();
    put_input(1, 16'h7FFF, 1'b0);
    put_weight(1, 0, 0, 16'h7FFF, 1'b0);
    put_weight(1, 0, 1, 16'h7FFF, 1'b0);
    put_weight(1, 1, 0, 16'h8000, 1'b0);
    put_weight(1, 1, 1, 16'h8000, 1'b0);
    put_weight(0, 5, 9, rand_q(), 1'b0);
    put_weight(3, 15, 15, rand_q(), 1'b1);
    put_input(15, 16'h0000, 1'b0);
    put_input(0, 16'h7FFF, 1'b1);
    settle();

    // deepest chain, one node per layer
    shape_layers = MFS_MAX_LAYERS;
    shape_nodes  = '{1, 1, 1, 1};
    program_shape();
    put_weight(2, 0, 0, 16'hF000, 1'b0);
    put_weight(3, 0, 0, 16'h7FFF, 1'b0);
    put_input(0, 16'h1000, 1'b1);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      settle();
      shape_layers = $urandom_range(1, MFS_MAX_LAYERS);
      for (int l = 0; l < MFS_MAX_LAYERS; l++) shape_nodes[l] = $urandom_range(1, 4);
      if ($urandom_range(0, 4) == 0)
        shape_nodes[$urandom_range(0, MFS_MAX_LAYERS - 1)] = MFS_MAX_NODES;
      program_shape();
      repeat ($urandom_range(1, 3)) random_pass();
    end
    settle();

    $display("%0d input items over %0d register settings", items_sent, configs_used);
    $display("%0d forward passes, %0d results compared", passes_run, results_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
